// ----- rtl/core/rlz_pkg.sv -----
package rlz_pkg;

    localparam int POS_W   = 19;
    localparam int LEN_W   = 13;
    localparam int VAL_W   = 8;
    localparam int DIST_W  = 12;
    localparam int PAL_W   = 9;
    localparam int BLANK_W = 10;
    localparam int CFG_W   = 19;
    localparam int COPY_WINDOW = 2048;

    // command formats selected by the mode register
    localparam logic [7:0] MODE_EMPTY = 8'd0;
    localparam logic [7:0] MODE_T3    = 8'd3;
    localparam logic [7:0] MODE_T4    = 8'd4;
    localparam logic [7:0] MODE_T5    = 8'd5;
    localparam logic [7:0] MODE_T7    = 8'd7;
    localparam logic [7:0] MODE_T255  = 8'd255;

    typedef enum logic [1:0] {
        CMD_SKIP = 2'd0,
        CMD_FILL = 2'd1,
        CMD_COPY = 2'd2
    } cmd_kind_t;

    typedef enum logic [1:0] {
        REG_MODE  = 2'd0,
        REG_START = 2'd1,
        REG_END   = 2'd2,
        REG_BLANK = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [POS_W-1:0]    start_pos;
        logic [LEN_W-1:0]    run_length;
        logic [VAL_W-1:0]    fill_value;
        logic [DIST_W-1:0]   copy_distance;
        logic [PAL_W-1:0]    palette_size;
        logic                frame_done;
        logic                bad_mode;
    } rlz_result_t;

    // handshake between the front end and the command queue
    typedef struct packed {
        logic        push;
        rlz_result_t data;
    } rlz_push_t;

endpackage

// ----- rtl/core/rlz_front.sv -----
module rlz_front import rlz_pkg::*; #(
    parameter int FRAME_PIXELS = 307200
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              in_accept,
    input  logic [7:0]        in_byte,
    input  logic              in_frame_start,
    output rlz_push_t         q_push
);

    localparam logic [POS_W-1:0] FRAME_MAX = POS_W'(FRAME_PIXELS);

    typedef struct packed {
        cmd_kind_t         kind;
        logic [LEN_W-1:0]  len;
        logic [VAL_W-1:0]  val;
        logic [DIST_W-1:0] copy_dist;
    } dec_t;

    logic [7:0]         mode_reg;
    logic [POS_W-1:0]   start_reg;
    logic [POS_W-1:0]   end_reg;
    logic [BLANK_W-1:0] blank_reg;

    logic [POS_W-1:0]   position_reg, position_next;
    logic [PAL_W-1:0]   pal_reg, pal_next;
    logic [7:0]         first_byte_reg, first_byte_next;
    logic               await_reg, await_next;
    logic               active_reg, active_next;

    logic [POS_W-1:0]   start_clamp;
    logic [POS_W-1:0]   pos_cur;
    logic [PAL_W-1:0]   pal_cur;
    logic               await_cur;
    logic               active_cur;
    logic               known;
    logic               emit;
    logic               decode_en;
    logic [7:0]         op;
    logic [7:0]         sec;
    dec_t               dec;
    logic [POS_W:0]     pos_sum;
    logic [POS_W-1:0]   pos_new;
    logic [PAL_W-1:0]   pal_new;

    function automatic logic wants_second(logic [7:0] m, logic [7:0] b);
        logic r;
        r = 1'b0;
        if (m == MODE_T3 || m == MODE_T4) begin
            if (b[7]) begin
                r = (b[6:5] == 2'b01);
            end else if (m == MODE_T3) begin
                r = (b[6:3] == 4'd0);
            end else begin
                r = (b[6:4] == 3'd0);
            end
        end else if (m == MODE_T5) begin
            r = (b[4:0] == 5'd0) || (b[7:5] == 3'd0);
        end else if (m == MODE_T7) begin
            r = (b[7:4] == 4'hd) || (b[7:6] == 2'b10);
        end else begin
            r = b[7];
        end
        return r;
    endfunction

    function automatic dec_t decode_cmd(logic [7:0] m, logic [7:0] o, logic [7:0] b,
                                        logic [BLANK_W-1:0] blank);
        dec_t d;
        logic [LEN_W-1:0] w;
        d = '0;
        d.kind = CMD_SKIP;
        w = '0;
        if (m == MODE_T3 || m == MODE_T4) begin
            if (o[7]) begin
                if (o[6]) begin
                    d.len = LEN_W'(blank) + LEN_W'(o[5:0]) + LEN_W'(1);
                end else if (o[5]) begin
                    w = {o[4:0], b};
                    d.len = w[12] ? {1'b0, w[11:0]} : w + LEN_W'(2);
                end else begin
                    d.len = LEN_W'(o[4:0]) + LEN_W'(2);
                end
            end else begin
                d.kind = CMD_FILL;
                if (m == MODE_T3) begin
                    d.val = VAL_W'(o[2:0]);
                    d.len = (o[6:3] != 4'd0) ? LEN_W'(o[6:3]) : LEN_W'(b);
                end else begin
                    d.val = VAL_W'(o[3:0]);
                    d.len = (o[6:4] != 3'd0) ? LEN_W'(o[6:4]) : LEN_W'(b);
                end
            end
        end else if (m == MODE_T5) begin
            if (o[4:0] == 5'd0) begin
                w = LEN_W'({o, 3'b000}) + LEN_W'(b);
                d.len = w[10] ? LEN_W'(w[9:0]) : w + LEN_W'(2);
            end else begin
                d.kind = CMD_FILL;
                d.val = VAL_W'(o[4:0]);
                d.len = (o[7:5] != 3'd0) ? LEN_W'(o[7:5]) : LEN_W'(b);
            end
        end else if (m == MODE_T7) begin
            if (o[7]) begin
                if (o[6]) begin
                    if (o[5]) begin
                        d.len = LEN_W'(blank) + LEN_W'(o[4:0]) + LEN_W'(1);
                    end else if (o[4]) begin
                        w = LEN_W'({o[3:0], b});
                        d.len = w[11] ? LEN_W'(w[10:0]) : w + LEN_W'(2);
                    end else begin
                        d.len = LEN_W'(o[3:0]) + LEN_W'(2);
                    end
                end else begin
                    d.kind = CMD_FILL;
                    d.len = LEN_W'(o[5:0]);
                    d.val = b;
                end
            end else begin
                d.kind = CMD_FILL;
                d.len = LEN_W'(1);
                d.val = o;
            end
        end else begin
            if (!o[7]) begin
                d.kind = CMD_FILL;
                d.len = LEN_W'(1);
                d.val = o;
            end else if (o[7:5] != 3'b111) begin
                d.kind = CMD_COPY;
                d.len = LEN_W'(o[6:3]) + LEN_W'(3);
                d.copy_dist = DIST_W'(COPY_WINDOW) - DIST_W'({o[2:0], b});
            end else if (!o[4]) begin
                d.kind = CMD_FILL;
                d.len = LEN_W'(o[3:0]) + LEN_W'(1);
                d.val = b;
            end else begin
                d.len = LEN_W'({o[3:0], b});
            end
        end
        return d;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_EMPTY;
            start_reg <= '0;
            end_reg   <= '0;
            blank_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MODE:  mode_reg  <= cfg_wdata[7:0];
                REG_START: start_reg <= cfg_wdata[POS_W-1:0];
                REG_END:   end_reg   <= cfg_wdata[POS_W-1:0];
                REG_BLANK: blank_reg <= cfg_wdata[BLANK_W-1:0];
            endcase
        end
    end

    always_comb begin
        start_clamp = (start_reg < FRAME_MAX) ? start_reg : FRAME_MAX;
        pos_cur     = in_frame_start ? start_clamp : position_reg;
        pal_cur     = in_frame_start ? PAL_W'(1) : pal_reg;
        await_cur   = in_frame_start ? 1'b0 : await_reg;
        active_cur  = in_frame_start ? (start_clamp < end_reg) : active_reg;

        known = (mode_reg == MODE_T3) || (mode_reg == MODE_T4) || (mode_reg == MODE_T5) ||
                (mode_reg == MODE_T7) || (mode_reg == MODE_T255);

        // pending first byte is paired with this one under the current mode
        op  = await_cur ? first_byte_reg : in_byte;
        sec = await_cur ? in_byte : 8'd0;
        dec = decode_cmd(mode_reg, op, sec, blank_reg);

        pos_sum = {1'b0, pos_cur} + (POS_W+1)'(dec.len);
        pos_new = (pos_sum > {1'b0, FRAME_MAX}) ? FRAME_MAX : pos_sum[POS_W-1:0];
        pal_new = (dec.kind == CMD_FILL && pal_cur <= PAL_W'(dec.val)) ?
                  PAL_W'(dec.val) + PAL_W'(1) : pal_cur;

        position_next   = pos_cur;
        pal_next        = pal_cur;
        first_byte_next = first_byte_reg;
        await_next      = await_cur;
        active_next     = active_cur;
        emit            = 1'b0;
        decode_en       = 1'b0;

        if (active_cur && mode_reg != MODE_EMPTY) begin
            if (!known) begin
                emit       = 1'b1;
                await_next = 1'b0;
            end else if (!await_cur && wants_second(mode_reg, in_byte)) begin
                first_byte_next = in_byte;
                await_next      = 1'b1;
            end else begin
                emit          = 1'b1;
                decode_en     = 1'b1;
                await_next    = 1'b0;
                position_next = pos_new;
                pal_next      = pal_new;
                active_next   = (pos_new < end_reg);
            end
        end

        q_push.push                    = in_accept && emit;
        q_push.data.kind               = decode_en ? dec.kind : CMD_SKIP;
        q_push.data.start_pos          = pos_cur;
        q_push.data.run_length         = decode_en ? dec.len : '0;
        q_push.data.fill_value         = decode_en ? dec.val : '0;
        q_push.data.copy_distance      = decode_en ? dec.copy_dist : '0;
        q_push.data.palette_size       = pal_next;
        q_push.data.frame_done         = (position_next >= end_reg);
        q_push.data.bad_mode           = !decode_en;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg   <= '0;
            pal_reg        <= PAL_W'(1);
            first_byte_reg <= '0;
            await_reg      <= 1'b0;
            active_reg     <= 1'b0;
        end else if (in_accept) begin
            position_reg   <= position_next;
            pal_reg        <= pal_next;
            first_byte_reg <= first_byte_next;
            await_reg      <= await_next;
            active_reg     <= active_next;
        end
    end

endmodule

// ----- rtl/core/rlz_queue.sv -----
module rlz_queue import rlz_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  rlz_push_t   q_push,
    output logic        q_full,
    input  logic        q_pop,
    output logic        q_empty,
    output rlz_result_t q_head
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    rlz_result_t        entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    always_comb begin
        q_full  = (count_reg == (PTR_W+1)'(DEPTH));
        q_empty = (count_reg == '0);
        q_head  = entry_reg[rd_ptr_reg];
        do_push = q_push.push && !q_full;
        do_pop  = q_pop && !q_empty;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + (PTR_W+1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= q_push.data;
        end
    end

endmodule

// ----- rtl/core/rlz_back.sv -----
module rlz_back import rlz_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_empty,
    input  rlz_result_t q_head,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    logic        valid_reg, valid_next;
    rlz_result_t out_reg;

    always_comb begin
        // advance when the output register is free or being drained
        q_pop      = !q_empty && (!valid_reg || m_tready);
        valid_next = valid_reg;
        if (q_pop) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_reg <= q_head;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'b000, out_reg.palette_size, out_reg.copy_distance,
                       out_reg.fill_value, out_reg.run_length, out_reg.start_pos};
    assign m_tuser  = {out_reg.bad_mode, out_reg.kind};
    assign m_tlast  = out_reg.frame_done;

endmodule

// ----- rtl/core/rle_lz_frame_command_decoder.sv -----
// Run-length / LZ frame command decoder.
// Input stream: one compressed byte per item on s_tdata[7:0]; s_tuser set on
// the first byte of a frame restarts the position at start_position and the
// palette size at one. Output stream: one pixel command per completed
// command (skip, fill or copy), with tlast set once the frame end is reached.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_index
// (0 mode, 1 start_position, 2 end_position, 3 blank_count); the user
// must write only while idle, as the block itself does not enforce it.
// Throughput: one byte per cycle while s_tready is high; each byte is
// classified and decoded in the cycle it is taken, and the position and
// palette registers update on the accepting edge. The edge that accepts
// the byte completing a command writes the queue; the output register
// then loads from the queue head when free or drained, raising m_tvalid.
// A two-entry queue sits between the decoder and the output register; when
// the receiver holds m_tready low, up to three results are buffered and then
// s_tready drops until the receiver takes an item and frees a queue entry.
// Reset (aresetn low, synchronous) clears the queue, the output valid, the
// configuration registers and the decoder state; no clearing pass is needed.
module rle_lz_frame_command_decoder import rlz_pkg::*; #(
    parameter int FRAME_PIXELS = 307200
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] data_byte
    input  logic             s_tuser,   // [0] frame_start
    output logic             m_tvalid,
    input  logic             m_tready,
    // [18:0] start_pos, [31:19] run_length, [39:32] fill_value,
    // [51:40] copy_distance, [60:52] palette_size, [63:61] zero
    output logic [63:0]      m_tdata,
    output logic [2:0]       m_tuser,   // [1:0] cmd_kind, [2] bad_mode
    output logic             m_tlast    // frame_done
);

    rlz_push_t   q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;
    rlz_result_t q_head;

    assign s_tready = !q_full;

    rlz_front #(
        .FRAME_PIXELS(FRAME_PIXELS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_accept      (s_tvalid && s_tready),
        .in_byte        (s_tdata),
        .in_frame_start (s_tuser),
        .q_push         (q_push)
    );

    rlz_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_empty (q_empty),
        .q_head  (q_head)
    );

    rlz_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- rtl/core/rlz_checker.sv -----
module rlz_stream_checks import rlz_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("stalled result changed");

    a_bad_mode_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tuser[1:0] == CMD_SKIP && m_tdata[31:19] == 13'd0
        && m_tdata[51:32] == 20'd0)
        else $error("bad-mode result carries a command");

    a_copy_distance: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser[1:0] == CMD_COPY) == (m_tdata[51:40] != 12'd0)))
        else $error("copy distance does not match command kind");

    a_palette: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[60:52] != 9'd0 && m_tdata[63:61] == 3'd0)
        else $error("palette size zero or padding set");

endmodule

bind rle_lz_frame_command_decoder rlz_stream_checks u_rlz_checker (.*);
